// ===== design/kt_pkg.sv =====
// Shared types and codes for the keyed table block.
// Used by keyed_table_insert_remove; has no dependencies of its own.
`default_nettype none

package kt_pkg;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [SLOT_W-1:0]   t_slot;

    // Result status codes.
    localparam t_status STATUS_DONE = 2'd0;
    localparam t_status STATUS_MISS = 2'd1;
    localparam t_status STATUS_FULL = 2'd2;

    // Operation codes.
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // One table entry as held in the table memory.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   name_key;
        logic [KEY_W-1:0]   surname_key;
        logic [VALUE_W-1:0] phone_value;
        logic [VALUE_W-1:0] mobile_value;
    } t_entry;

endpackage : kt_pkg

`default_nettype wire

// ===== design/keyed_table_insert_remove.sv =====
// Top level of the keyed table: sequencer, scan compare and result register.
// Depends on kt_pkg and kt_ram.
`default_nettype none

// The block keeps a table of TABLE_DEPTH entries, each holding a valid mark,
// a pair of 64-bit keys (name and surname) and two 64-bit value words, all in
// one memory with a registered read port. An add beat stores the item in the
// lowest free slot unless a valid entry already carries the same key pair; a
// remove beat clears the lowest valid entry whose key pair matches. Every
// input beat yields exactly one result beat with a status (done, duplicate or
// not found, table full) and the slot touched, which is zero whenever the
// status is not done; for tables deeper than 128 the slot is reported modulo
// 128. After reset the block sweeps the memory once to clear every valid
// mark, and it takes no input during the sweep. Each item then passes
// through these steps from acceptance to its result being presented:
// priming the registered read, one full pass of the single memory read
// port over every slot, feeding one shared key comparator, deciding and
// writing back, and loading the result register. Ready returns in the
// cycle in which the result appears. The block takes one item at a time;
// it may accept the next item while the previous result still waits in
// the output register, and a finished result that finds the output
// register still occupied holds the block until the receiver takes it.

module keyed_table_insert_remove #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_op,
    input  logic [kt_pkg::KEY_W-1:0]   i_name_key,
    input  logic [kt_pkg::KEY_W-1:0]   i_surname_key,
    input  logic [kt_pkg::VALUE_W-1:0] i_phone_value,
    input  logic [kt_pkg::VALUE_W-1:0] i_mobile_value,
    // Result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output kt_pkg::t_status          o_status,
    output kt_pkg::t_slot            o_slot
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = $bits(kt_pkg::t_entry);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]                 r_state, n_state;
    logic [AW-1:0]              r_addr, n_addr;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]              r_cmp_idx, n_cmp_idx;
    logic                       r_hit_found, n_hit_found;
    logic [AW-1:0]              r_hit_idx, n_hit_idx;
    logic                       r_free_found, n_free_found;
    logic [AW-1:0]              r_free_idx, n_free_idx;

    // Latched input item.
    logic                       r_op, n_op;
    logic [kt_pkg::KEY_W-1:0]   r_name_key, n_name_key;
    logic [kt_pkg::KEY_W-1:0]   r_surname_key, n_surname_key;
    logic [kt_pkg::VALUE_W-1:0] r_phone_value, n_phone_value;
    logic [kt_pkg::VALUE_W-1:0] r_mobile_value, n_mobile_value;

    // Result waiting for the output register, and the output register itself.
    kt_pkg::t_status            r_res_status, n_res_status;
    logic [AW-1:0]              r_res_idx, n_res_idx;
    logic                       r_out_valid, n_out_valid;
    kt_pkg::t_status            r_out_status, n_out_status;
    kt_pkg::t_slot              r_out_slot, n_out_slot;

    // Memory port signals.
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    kt_pkg::t_entry             ram_wentry;
    logic [ENTRY_W-1:0]         ram_rdata;
    kt_pkg::t_entry             rd_entry;

    logic                       in_beat;
    logic                       out_beat;
    logic                       key_match;
    logic                       out_free;

    kt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = kt_pkg::t_entry'(ram_rdata);
    assign key_match = rd_entry.valid
                       && (rd_entry.name_key == r_name_key)
                       && (rd_entry.surname_key == r_surname_key);

    assign o_ready  = (r_state == S_IDLE);
    assign in_beat  = i_valid && o_ready;
    assign out_beat = r_out_valid && i_ready;
    assign out_free = !r_out_valid || i_ready;

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_slot   = r_out_slot;

    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_cmp_vld      = r_cmp_vld;
        n_cmp_idx      = r_cmp_idx;
        n_hit_found    = r_hit_found;
        n_hit_idx      = r_hit_idx;
        n_free_found   = r_free_found;
        n_free_idx     = r_free_idx;
        n_op           = r_op;
        n_name_key     = r_name_key;
        n_surname_key  = r_surname_key;
        n_phone_value  = r_phone_value;
        n_mobile_value = r_mobile_value;
        n_res_status   = r_res_status;
        n_res_idx      = r_res_idx;
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_slot     = r_out_slot;

        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wentry = '0;

        if (out_beat) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Post-reset sweep: one entry cleared each cycle.
                ram_we     = 1'b1;
                ram_waddr  = r_addr;
                ram_wentry = '0;
                if (r_addr == LAST_SLOT) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_beat) begin
                    n_op           = i_op;
                    n_name_key     = i_name_key;
                    n_surname_key  = i_surname_key;
                    n_phone_value  = i_phone_value;
                    n_mobile_value = i_mobile_value;
                    n_addr         = '0;
                    n_cmp_vld      = 1'b0;
                    n_hit_found    = 1'b0;
                    n_free_found   = 1'b0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                // The read address runs one slot ahead of the comparison,
                // matching the registered read of the memory.
                n_addr    = (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_addr;
                if (r_cmp_vld) begin
                    if (key_match && !r_hit_found) begin
                        n_hit_found = 1'b1;
                        n_hit_idx   = r_cmp_idx;
                    end
                    if (!rd_entry.valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cmp_idx;
                    end
                    if (r_cmp_idx == LAST_SLOT) begin
                        n_cmp_vld = 1'b0;
                        n_state   = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                n_res_idx = '0;
                ram_wentry.valid        = (r_op == kt_pkg::OP_ADD);
                ram_wentry.name_key     = r_name_key;
                ram_wentry.surname_key  = r_surname_key;
                ram_wentry.phone_value  = r_phone_value;
                ram_wentry.mobile_value = r_mobile_value;
                if (r_op == kt_pkg::OP_ADD) begin
                    if (r_hit_found) begin
                        n_res_status = kt_pkg::STATUS_MISS;
                    end else if (r_free_found) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_free_idx;
                        n_res_status = kt_pkg::STATUS_DONE;
                        n_res_idx    = r_free_idx;
                    end else begin
                        n_res_status = kt_pkg::STATUS_FULL;
                    end
                end else begin
                    if (r_hit_found) begin
                        // Removal only needs the valid mark cleared.
                        ram_we       = 1'b1;
                        ram_waddr    = r_hit_idx;
                        n_res_status = kt_pkg::STATUS_DONE;
                        n_res_idx    = r_hit_idx;
                    end else begin
                        n_res_status = kt_pkg::STATUS_MISS;
                    end
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = kt_pkg::SLOT_W'(r_res_idx);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_cmp_vld    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_cmp_vld    <= n_cmp_vld;
            r_hit_found  <= n_hit_found;
            r_free_found <= n_free_found;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx      <= n_cmp_idx;
        r_hit_idx      <= n_hit_idx;
        r_free_idx     <= n_free_idx;
        r_op           <= n_op;
        r_name_key     <= n_name_key;
        r_surname_key  <= n_surname_key;
        r_phone_value  <= n_phone_value;
        r_mobile_value <= n_mobile_value;
        r_res_status   <= n_res_status;
        r_res_idx      <= n_res_idx;
        r_out_status   <= n_out_status;
        r_out_slot     <= n_out_slot;
    end

    // A result that is not done never reports a slot.
    a_slot_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != kt_pkg::STATUS_DONE)) |-> (r_out_slot == '0))
        else $error("nonzero slot reported with a failing status");

    // The table is written only by the clearing sweep or the decision step.
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) || (r_state == S_DECIDE)))
        else $error("table written outside the sweep or decision step");

    // An accepted beat always starts a scan.
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a scan");

    // Status codes carried out are only the three defined ones.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_status == kt_pkg::STATUS_DONE)
                      || (r_out_status == kt_pkg::STATUS_MISS)
                      || (r_out_status == kt_pkg::STATUS_FULL)))
        else $error("undefined status code on the result channel");

endmodule : keyed_table_insert_remove

`default_nettype wire

// ===== design/kt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.
`default_nettype none

module kt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : kt_ram

`default_nettype wire
